@@ sv/vqdm_pkg.sv @@
// ---------------------------------------------------------------------------
// vqdm_pkg
// Shared widths, operation and status codes, and the handshake structs of the
// virtqueue descriptor manager.
// ---------------------------------------------------------------------------
package vqdm_pkg;

   // Field widths
   localparam int OpcodeWidth = 3;
   localparam int IndexWidth  = 8;
   localparam int RingWidth   = 16;
   localparam int SizeWidth   = 9;
   localparam int StatusWidth = 2;

   // Link table depth and its address width
   localparam int MaxQueue    = 256;
   localparam int AddrWidth   = $clog2(MaxQueue);

   // Largest queue size the index fields can address
   localparam int MaxSize     = 2 ** IndexWidth;
   localparam logic [SizeWidth-1:0] SizeCap =
      SizeWidth'((MaxQueue < MaxSize) ? MaxQueue : MaxSize);

   // Operation codes
   localparam logic [OpcodeWidth-1:0] OpInit    = 3'd0;
   localparam logic [OpcodeWidth-1:0] OpAlloc   = 3'd1;
   localparam logic [OpcodeWidth-1:0] OpFree    = 3'd2;
   localparam logic [OpcodeWidth-1:0] OpPublish = 3'd3;
   localparam logic [OpcodeWidth-1:0] OpConsume = 3'd4;

   // Status codes
   localparam logic [StatusWidth-1:0] StatusOk     = 2'd0;
   localparam logic [StatusWidth-1:0] StatusNoFree = 2'd1;
   localparam logic [StatusWidth-1:0] StatusNoNew  = 2'd2;
   localparam logic [StatusWidth-1:0] StatusBad    = 2'd3;

   // Free list commands (at most one set per transaction)
   typedef struct packed {
      logic                  do_init;
      logic                  do_pop;
      logic                  do_push;
      logic [IndexWidth-1:0] push_index;
   } fl_cmd_type;

   // Free list state seen by the top level
   typedef struct packed {
      logic [IndexWidth-1:0] head;
      logic [SizeWidth-1:0]  free_total;
      logic [SizeWidth-1:0]  free_total_next;
   } fl_stat_type;

   // Ring index commands
   typedef struct packed {
      logic                 do_init;
      logic                 do_publish;
      logic                 consume_req;
      logic [RingWidth-1:0] device_used;
   } ri_cmd_type;

   // Ring index results
   typedef struct packed {
      logic                  used_empty;
      logic [IndexWidth-1:0] slot;
      logic [RingWidth-1:0]  avail_next;
   } ri_stat_type;

   // Effective size: clamp to 1..SizeCap, then round down to a power of two
   function automatic logic [SizeWidth-1:0] eff_size(input logic [SizeWidth-1:0] value);
      logic [SizeWidth-1:0] clamped;
      logic [SizeWidth-1:0] result;
      clamped = value;
      if (clamped == '0) begin
         clamped = SizeWidth'(1);
      end
      if (clamped > SizeCap) begin
         clamped = SizeCap;
      end
      result = '0;
      for (int b = 0; b < SizeWidth; b++) begin
         if (clamped[b]) begin
            result = SizeWidth'(1) << b;
         end
      end
      return result;
   endfunction

endpackage

@@ sv/vqdm_ram.sv @@
// ---------------------------------------------------------------------------
// vqdm_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module vqdm_ram #(
   parameter int DataWidth = 8,
   parameter int Depth     = 256
) (
   input  logic                         clock,
   input  logic                         write_enable,
   input  logic [$clog2(Depth)-1:0]     write_addr,
   input  logic [DataWidth-1:0]         write_data,
   input  logic [$clog2(Depth)-1:0]     read_addr,
   output logic [DataWidth-1:0]         read_data
);

   logic [DataWidth-1:0] mem_ff [Depth];
   logic [DataWidth-1:0] read_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
   end

   // Registered read port, returns old data on a same-address write
   always_ff @(posedge clock) begin
      read_data_ff <= mem_ff[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

@@ sv/vqdm_free_list.sv @@
// ---------------------------------------------------------------------------
// vqdm_free_list
// Linked free list of descriptor indices: head pointer, free count, fresh bits
// and the link RAM. The RAM is always reading the entry of the next head, so
// the link behind the current head is ready when an alloc arrives.
// ---------------------------------------------------------------------------
module vqdm_free_list (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [vqdm_pkg::SizeWidth-1:0] size,
   input  vqdm_pkg::fl_cmd_type          cmd,
   output vqdm_pkg::fl_stat_type         stat
);
   import vqdm_pkg::*;

   logic [IndexWidth-1:0] head_ff, head_in;
   logic [SizeWidth-1:0]  total_ff, total_in;
   logic [MaxQueue-1:0]   fresh_ff;
   logic                  bypass_valid_ff, bypass_valid_in;
   logic [IndexWidth-1:0] bypass_data_ff;

   logic [AddrWidth-1:0]  head_addr;
   logic [AddrWidth-1:0]  write_addr;
   logic [AddrWidth-1:0]  read_addr;
   logic [IndexWidth-1:0] ram_rdata;
   logic [SizeWidth-1:0]  head_plus;
   logic [IndexWidth-1:0] default_link;
   logic [IndexWidth-1:0] stored_link;
   logic [IndexWidth-1:0] next_link;

   assign head_addr  = AddrWidth'(head_ff);
   assign write_addr = AddrWidth'(cmd.push_index);
   assign read_addr  = AddrWidth'(head_in);

   // Link behind the head: default chain if fresh, else RAM or same-edge bypass
   assign head_plus    = {1'b0, head_ff} + SizeWidth'(1);
   assign default_link = (head_plus >= size) ? '0 : head_plus[IndexWidth-1:0];
   assign stored_link  = bypass_valid_ff ? bypass_data_ff : ram_rdata;
   assign next_link    = fresh_ff[head_addr] ? default_link : stored_link;

   // Next head and count
   always_comb begin
      head_in  = head_ff;
      total_in = total_ff;
      priority if (cmd.do_init) begin
         head_in  = '0;
         total_in = size;
      end else if (cmd.do_pop) begin
         head_in  = next_link;
         total_in = total_ff - SizeWidth'(1);
      end else if (cmd.do_push) begin
         head_in  = cmd.push_index;
         total_in = total_ff + SizeWidth'(1);
      end
   end

   // A write to the address being read this edge is forwarded next cycle
   assign bypass_valid_in = cmd.do_push && (write_addr == read_addr);

   vqdm_ram #(
      .DataWidth(IndexWidth),
      .Depth    (MaxQueue)
   ) u_link_ram (
      .clock       (clock),
      .write_enable(cmd.do_push),
      .write_addr  (write_addr),
      .write_data  (head_ff),
      .read_addr   (read_addr),
      .read_data   (ram_rdata)
   );

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff         <= '0;
         total_ff        <= eff_size(SizeWidth'(MaxSize));
         fresh_ff        <= '1;
         bypass_valid_ff <= 1'b0;
      end else begin
         head_ff         <= head_in;
         total_ff        <= total_in;
         bypass_valid_ff <= bypass_valid_in;
         if (cmd.do_init) begin
            fresh_ff <= '1;
         end else if (cmd.do_push) begin
            fresh_ff[write_addr] <= 1'b0;
         end
      end
   end

   // Forwarded link data
   always_ff @(posedge clock) begin
      bypass_data_ff <= head_ff;
   end

   assign stat.head            = head_ff;
   assign stat.free_total      = total_ff;
   assign stat.free_total_next = total_in;

endmodule

@@ sv/vqdm_ring_index.sv @@
// ---------------------------------------------------------------------------
// vqdm_ring_index
// Available ring index and last-seen used index, with slot masking.
// ---------------------------------------------------------------------------
module vqdm_ring_index (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [vqdm_pkg::IndexWidth-1:0] mask,
   input  vqdm_pkg::ri_cmd_type            cmd,
   output vqdm_pkg::ri_stat_type           stat
);
   import vqdm_pkg::*;

   logic [RingWidth-1:0] avail_ff, avail_in;
   logic [RingWidth-1:0] used_ff, used_in;
   logic                 used_empty;
   logic [IndexWidth-1:0] slot;

   assign used_empty = (used_ff == cmd.device_used);

   // Index updates and slot selection
   always_comb begin
      avail_in = avail_ff;
      used_in  = used_ff;
      slot     = '0;
      priority if (cmd.do_init) begin
         used_in = '0;
      end else if (cmd.do_publish) begin
         slot     = avail_ff[IndexWidth-1:0] & mask;
         avail_in = avail_ff + RingWidth'(1);
      end else if (cmd.consume_req && !used_empty) begin
         slot    = used_ff[IndexWidth-1:0] & mask;
         used_in = used_ff + RingWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avail_ff <= '0;
         used_ff  <= '0;
      end else begin
         avail_ff <= avail_in;
         used_ff  <= used_in;
      end
   end

   assign stat.used_empty = used_empty;
   assign stat.slot       = slot;
   assign stat.avail_next = avail_in;

endmodule

@@ sv/virtqueue_descriptor_manager.sv @@
// ---------------------------------------------------------------------------
// virtqueue_descriptor_manager
// Driver-side bookkeeping for one split virtqueue: descriptor free list,
// available index and used index tracking.
//
//   Channel  Direction  Handshake                  Payload
//   req      in         req_valid / req_stall      opcode, desc_index,
//                                                  device_used_index
//   rsp      out        rsp_valid / rsp_stall      status, granted_index,
//                                                  ring_slot, avail_count,
//                                                  free_left
//   csr      in         csr_write_enable           descriptor count in use
//
// One transaction per cycle while req_stall is low; its result is captured
// in the output register on acceptance. The rate rests on the link RAM
// read, which always tracks the next list head so each alloc finds its
// link ready. Synchronous reset restores all control state (fresh bits
// mark the whole link table as default chain); no clearing pass.
// req_stall is high only while a result is held and rsp_stall is high.
// ---------------------------------------------------------------------------
module virtqueue_descriptor_manager (
   input  logic                             clock,
   input  logic                             reset,
   // Request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [vqdm_pkg::OpcodeWidth-1:0] req_opcode,
   input  logic [vqdm_pkg::IndexWidth-1:0]  req_desc_index,
   input  logic [vqdm_pkg::RingWidth-1:0]   req_device_used_index,
   // Response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [vqdm_pkg::StatusWidth-1:0] rsp_status,
   output logic [vqdm_pkg::IndexWidth-1:0]  rsp_granted_index,
   output logic [vqdm_pkg::IndexWidth-1:0]  rsp_ring_slot,
   output logic [vqdm_pkg::RingWidth-1:0]   rsp_avail_count,
   output logic [vqdm_pkg::SizeWidth-1:0]   rsp_free_left,
   // Configuration
   input  logic                             csr_write_enable,
   input  logic [vqdm_pkg::SizeWidth-1:0]   csr_write_data
);
   import vqdm_pkg::*;

   logic                   accept;
   logic [SizeWidth-1:0]   size_ff;
   logic [IndexWidth-1:0]  mask;
   logic                   index_bad;
   fl_cmd_type             fl_cmd;
   fl_stat_type            fl_stat;
   ri_cmd_type             ri_cmd;
   ri_stat_type            ri_stat;
   logic [StatusWidth-1:0] status;
   logic [IndexWidth-1:0]  granted;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [StatusWidth-1:0] status_ff;
   logic [IndexWidth-1:0]  granted_ff;
   logic [IndexWidth-1:0]  slot_ff;
   logic [RingWidth-1:0]   avail_ff;
   logic [SizeWidth-1:0]   free_left_ff;

   // Handshake
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // Effective queue size, stored already rounded to a power of two
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= eff_size(SizeWidth'(MaxSize));
      end else if (csr_write_enable) begin
         size_ff <= eff_size(csr_write_data);
      end
   end

   assign mask      = IndexWidth'(size_ff - SizeWidth'(1));
   assign index_bad = ({1'b0, req_desc_index} >= size_ff);

   // Decode and checks
   always_comb begin
      fl_cmd             = '0;
      fl_cmd.push_index  = req_desc_index;
      ri_cmd             = '0;
      ri_cmd.device_used = req_device_used_index;
      status             = StatusOk;
      granted            = '0;
      unique case (req_opcode)
         OpInit: begin
            fl_cmd.do_init = accept;
            ri_cmd.do_init = accept;
         end
         OpAlloc: begin
            if (fl_stat.free_total == '0) begin
               status = StatusNoFree;
            end else begin
               fl_cmd.do_pop = accept;
               granted       = fl_stat.head;
            end
         end
         OpFree: begin
            if (index_bad || (fl_stat.free_total >= size_ff)) begin
               status = StatusBad;
            end else begin
               fl_cmd.do_push = accept;
            end
         end
         OpPublish: begin
            if (index_bad) begin
               status = StatusBad;
            end else begin
               ri_cmd.do_publish = accept;
            end
         end
         OpConsume: begin
            ri_cmd.consume_req = accept;
            if (ri_stat.used_empty) begin
               status = StatusNoNew;
            end
         end
         default: begin
         end
      endcase
   end

   vqdm_free_list u_free_list (
      .clock(clock),
      .reset(reset),
      .size (size_ff),
      .cmd  (fl_cmd),
      .stat (fl_stat)
   );

   vqdm_ring_index u_ring_index (
      .clock(clock),
      .reset(reset),
      .mask (mask),
      .cmd  (ri_cmd),
      .stat (ri_stat)
   );

   // Output register
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff    <= status;
         granted_ff   <= granted;
         slot_ff      <= ri_stat.slot;
         avail_ff     <= ri_stat.avail_next;
         free_left_ff <= fl_stat.free_total_next;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_granted_index = granted_ff;
   assign rsp_ring_slot     = slot_ff;
   assign rsp_avail_count   = avail_ff;
   assign rsp_free_left     = free_left_ff;

endmodule
